// ===== src/quadratic_probe_hash_table_core_defines.svh =====
// Assertion macros shared by the hash table core.
// Depends on nothing; the including module supplies clk and rst.
`ifndef QUADRATIC_PROBE_HASH_TABLE_CORE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QPHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/qpht_pkg.sv =====
// Constants, status codes and the modular adder of the hash table core.
// Depends on nothing.
package qpht_pkg;

  localparam int KEY_W              = 31;
  localparam int SIZE_W             = 9;
  localparam int STATUS_W           = 2;
  localparam int DEFAULT_TABLE_DEPTH = 256;
  // table_size is 9 bits wide, so no slot at or above this index is ever probed.
  localparam int MAX_SLOTS          = 512;
  localparam int BIT_W              = $clog2(KEY_W);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // (a + b + cin) mod n, valid while the sum stays below 2n.
  function automatic logic [SIZE_W-1:0] mod_add(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b,
                                                input logic              cin,
                                                input logic [SIZE_W-1:0] n);
    logic [SIZE_W:0] sum;
    logic [SIZE_W:0] diff;
    begin
      sum  = {1'b0, a} + {1'b0, b} + {{SIZE_W{1'b0}}, cin};
      diff = sum - {1'b0, n};
      mod_add = (sum >= {1'b0, n}) ? diff[SIZE_W-1:0] : sum[SIZE_W-1:0];
    end
  endfunction

endpackage

// ===== src/quadratic_probe_hash_table_core.sv =====
// Open-addressing hash table with quadratic probing: top level and only module.
// Depends on qpht_pkg and quadratic_probe_hash_table_core_defines.svh.
// Flow: the key is reduced mod the clamped size by a 31-step bit-serial hash, the home slot
// is fetched, then one slot memory read is made per probe, up to table size probes.
// A new transaction is taken only after the result is loaded into the output register.
// Reset: a clearing pass writes all min(TABLE_DEPTH, 512) slots; table_size resets to 256.
`include "quadratic_probe_hash_table_core_defines.svh"

module quadratic_probe_hash_table_core #(
  parameter int TABLE_DEPTH = qpht_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qpht_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [qpht_pkg::KEY_W-1:0]    key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qpht_pkg::STATUS_W-1:0] status
);
  import qpht_pkg::*;

  localparam int MEM_DEPTH = (TABLE_DEPTH < MAX_SLOTS) ? TABLE_DEPTH : MAX_SLOTS;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int ENTRY_W   = KEY_W + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_FETCH = 6'b001000,
    S_PROBE = 6'b010000,
    S_HOLD  = 6'b100000
  } state_t;

  state_t               state;
  logic [SIZE_W-1:0]    table_size;
  logic [SIZE_W-1:0]    n_reg;
  logic [SIZE_W-1:0]    n_next;
  logic                 act_reg;
  logic [KEY_W-1:0]     key_reg;
  logic [BIT_W-1:0]     bit_idx;
  logic [SIZE_W-1:0]    pos;
  logic [SIZE_W-1:0]    chk_pos;
  logic [SIZE_W-1:0]    step;
  logic [SIZE_W-1:0]    left;
  logic [AW-1:0]        clr_addr;
  logic [STATUS_W-1:0]  pend_status;

  logic [ENTRY_W-1:0]   mem [MEM_DEPTH];
  logic [ENTRY_W-1:0]   rd_data;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [ENTRY_W-1:0]   wdata;

  logic [SIZE_W-1:0]    add_a;
  logic [SIZE_W-1:0]    add_b;
  logic                 add_cin;
  logic [SIZE_W-1:0]    add_res;
  logic [SIZE_W-1:0]    step_res;

  logic                 in_fire;
  logic                 out_free;
  logic                 out_load;
  logic                 slot_used;
  logic                 key_hit;
  logic                 probe_done;
  logic [STATUS_W-1:0]  probe_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = out_free && ((state == S_PROBE && probe_done) || state == S_HOLD);

  // Zero acts as one slot; sizes above the depth saturate.
  always_comb begin
    priority if (table_size == '0) begin
      n_next = SIZE_W'(1);
    end else if ({23'b0, table_size} > 32'(TABLE_DEPTH)) begin
      n_next = SIZE_W'(TABLE_DEPTH);
    end else begin
      n_next = table_size;
    end
  end

  // The shared modular adder: doubles the remainder while hashing, adds the
  // probe step (2i+1 mod n_reg) while probing.
  always_comb begin
    if (state == S_HASH) begin
      add_a   = pos;
      add_b   = pos;
      add_cin = key_reg[bit_idx];
    end else begin
      add_a   = pos;
      add_b   = step;
      add_cin = 1'b0;
    end
  end
  assign add_res  = mod_add(add_a, add_b, add_cin, n_reg);
  // Successive squares differ by 2i+1, so the step grows by two per probe.
  assign step_res = mod_add(step, SIZE_W'(2), 1'b0, n_reg);

  assign slot_used = rd_data[ENTRY_W-1];
  assign key_hit   = (rd_data[KEY_W-1:0] == key_reg);

  always_comb begin
    probe_done   = 1'b1;
    probe_status = ST_MISSING;
    priority if (!slot_used) begin
      probe_status = (act_reg == ACT_INSERT) ? ST_INSERTED : ST_MISSING;
    end else if (act_reg == ACT_SEARCH && key_hit) begin
      probe_status = ST_FOUND;
    end else if (left == '0) begin
      probe_status = (act_reg == ACT_INSERT) ? ST_FULL : ST_MISSING;
    end else begin
      probe_done = 1'b0;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (state == S_PROBE && !slot_used && act_reg == ACT_INSERT) begin
      we    = 1'b1;
      waddr = chk_pos[AW-1:0];
      wdata = {1'b1, key_reg};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      table_size <= SIZE_RESET;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        table_size <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            act_reg <= action;
            key_reg <= key;
            n_reg   <= n_next;
            pos     <= '0;
            step    <= (n_next == SIZE_W'(1)) ? '0 : SIZE_W'(1);
            bit_idx <= BIT_W'(KEY_W - 1);
            state   <= S_HASH;
          end
        end
        S_HASH: begin
          pos     <= add_res;
          bit_idx <= bit_idx - BIT_W'(1);
          if (bit_idx == '0) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          // The read of the home slot is in flight; start the next one.
          chk_pos <= pos;
          pos     <= add_res;
          step    <= step_res;
          left    <= n_reg - SIZE_W'(1);
          state   <= S_PROBE;
        end
        S_PROBE: begin
          if (probe_done) begin
            if (out_free) begin
              status <= probe_status;
              state  <= S_IDLE;
            end else begin
              pend_status <= probe_status;
              state       <= S_HOLD;
            end
          end else begin
            chk_pos <= pos;
            pos     <= add_res;
            step    <= step_res;
            left    <= left - SIZE_W'(1);
          end
        end
        S_HOLD: begin
          if (out_free) begin
            status <= pend_status;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `QPHT_ASSERT_NOW(a_probe_in_range,
                   (state == S_HASH || state == S_FETCH || state == S_PROBE),
                   (pos < n_reg), "probe index left the active table")
  `QPHT_ASSERT_NOW(a_left_bounded, (state == S_PROBE), (left < n_reg),
                   "probe count exceeds table size")
  `QPHT_ASSERT_NOW(a_write_on_insert, (we && state != S_CLEAR),
                   (state == S_PROBE && act_reg == ACT_INSERT),
                   "slot written outside an insert")
  `QPHT_ASSERT_NEXT(a_busy_after_accept, in_fire, (state == S_HASH && !in_ready),
                    "block not busy after an accepted transaction")

endmodule
